[hdl/byte_stack_with_der_pop_assert.svh]
// Assertion macros used by the byte stack RTL.
// Depends on nothing; included by bsdp_ctrl to check its own logic.
`ifndef BYTE_STACK_WITH_DER_POP_ASSERT_SVH
`define BYTE_STACK_WITH_DER_POP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BSDP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSDP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bsdp_pkg.sv]
// Shared types and constants for the byte stack with DER pop.
// No dependencies; used by controller, datapath and top level.
package bsdp_pkg;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_KEY  = 2'd2,
    KIND_SIG  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_FORMAT    = 3'd3,
    ST_TOOLONG   = 3'd4
  } status_t;

  localparam int unsigned KEY_LEN = 33;
  localparam int unsigned IDX_W   = $clog2(KEY_LEN);
  localparam logic [IDX_W-1:0] KEY_LAST_IDX = IDX_W'(KEY_LEN - 1);

  localparam logic [7:0] DER_MARK    = 8'h30;
  localparam logic [7:0] KEY_PFX_EVN = 8'h02;
  localparam logic [7:0] KEY_PFX_ODD = 8'h03;

  // Commands from controller to datapath.
  typedef struct packed {
    logic    push;
    logic    pop;
    logic    emit;
    logic    use_data;
    status_t status;
    logic    last;
    logic    save_first;
    logic    load_len;
    logic    dec_len;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic is_mark;
    logic len_ok;
    logic len_zero;
    logic len_one;
    logic first_ok;
  } dp_stat_t;

endpackage

[hdl/byte_stack_with_der_pop.sv]
// Byte LIFO with push, pop, 33-byte key pop and DER signature pop; results cannot be stalled.
// Push: result in the cycle after start, busy stays low, one item per cycle.
// Pop: each popped byte takes a memory read in S_FETCH, then its result from S_EMIT.
// Key pop repeats these steps for 33 bytes, signature pop for 2+L bytes; an empty fetch ends the item early.
// Synchronous active-low reset clears fill count and controller; memory is not cleared.
module byte_stack_with_der_pop #(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned SIG_LIMIT   = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_byte_in,
  output logic       out_valid,
  output logic [7:0] out_data_out,
  output logic       out_has_data,
  output logic [2:0] out_status,
  output logic       out_last
);
  import bsdp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bsdp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  bsdp_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .SIG_LIMIT   (SIG_LIMIT)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_byte_in   (in_byte_in),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_data_out (out_data_out),
    .out_has_data (out_has_data),
    .out_status   (out_status),
    .out_last     (out_last)
  );

endmodule

[hdl/bsdp_datapath.sv]
// Datapath: stack memory, fill count, read register, length counter and result registers.
// Depends on bsdp_pkg; driven by bsdp_ctrl.
module bsdp_datapath #(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned SIG_LIMIT   = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_byte_in,
  input  bsdp_pkg::dp_cmd_t cmd,
  output bsdp_pkg::dp_stat_t stat,
  output logic              out_valid,
  output logic [7:0]        out_data_out,
  output logic              out_has_data,
  output logic [2:0]        out_status,
  output logic              out_last
);
  import bsdp_pkg::*;

  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LEN_W  = $clog2(SIG_LIMIT);

  logic [7:0]       mem [STACK_DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] cnt_m1;
  logic [7:0]       rd_data_r;
  logic [7:0]       first_r;
  logic [LEN_W-1:0] len_r;
  logic             valid_r;
  logic [7:0]       data_r;
  logic             has_r;
  logic [2:0]       status_r;
  logic             last_r;
  logic             do_write;

  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign do_write = cmd.push && !stat.full;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_write) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.pop) begin
      cnt_nxt = cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      valid_r <= cmd.emit;
    end
  end

  // Stack memory: write on push when not full, registered read of the top entry on pop.
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[cnt_r[ADDR_W-1:0]] <= in_byte_in;
    end
    if (cmd.pop) begin
      rd_data_r <= mem[cnt_m1[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.save_first) begin
      first_r <= rd_data_r;
    end
    if (cmd.load_len) begin
      len_r <= rd_data_r[LEN_W-1:0];
    end else if (cmd.dec_len) begin
      len_r <= len_r - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      data_r   <= cmd.use_data ? rd_data_r : 8'd0;
      has_r    <= cmd.use_data;
      status_r <= cmd.status;
      last_r   <= cmd.last;
    end
  end

  always_comb begin
    stat.empty    = (cnt_r == '0);
    stat.full     = (cnt_r == CNT_W'(STACK_DEPTH));
    stat.is_mark  = (rd_data_r == DER_MARK);
    stat.len_ok   = (({1'b0, rd_data_r} + 9'd2) <= 9'(SIG_LIMIT));
    stat.len_zero = (rd_data_r == 8'd0);
    stat.len_one  = (len_r == LEN_W'(1));
    stat.first_ok = (first_r == KEY_PFX_EVN) || (first_r == KEY_PFX_ODD);
  end

  assign out_valid    = valid_r;
  assign out_data_out = data_r;
  assign out_has_data = has_r;
  assign out_status   = status_r;
  assign out_last     = last_r;

endmodule

[hdl/bsdp_ctrl.sv]
// Controller: sequences push, pop, key pop and signature pop one byte at a time.
// Depends on bsdp_pkg and the assertion header; drives bsdp_datapath.
module bsdp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_kind,
  input  bsdp_pkg::dp_stat_t stat,
  output bsdp_pkg::dp_cmd_t  cmd,
  output logic               busy
);
  import bsdp_pkg::*;
  `include "byte_stack_with_der_pop_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  kind_t            kind_r, kind_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (kind_t'(in_kind) == KIND_PUSH) begin
            cmd.push   = 1'b1;
            cmd.emit   = 1'b1;
            cmd.status = stat.full ? ST_OVERFLOW : ST_OK;
            cmd.last   = 1'b1;
          end else begin
            kind_nxt  = kind_t'(in_kind);
            idx_nxt   = '0;
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        if (stat.empty) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_UNDERFLOW;
          cmd.last   = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit     = 1'b1;
        cmd.use_data = 1'b1;
        state_nxt    = S_FETCH;
        case (kind_r)
          KIND_KEY: begin
            cmd.save_first = (idx_r == '0);
            if (idx_r == KEY_LAST_IDX) begin
              cmd.status = stat.first_ok ? ST_OK : ST_FORMAT;
              cmd.last   = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              idx_nxt = idx_r + IDX_W'(1);
            end
          end
          KIND_SIG: begin
            if (idx_r == IDX_W'(0)) begin
              if (!stat.is_mark) begin
                cmd.status = ST_FORMAT;
                cmd.last   = 1'b1;
                state_nxt  = S_IDLE;
              end else begin
                idx_nxt = IDX_W'(1);
              end
            end else if (idx_r == IDX_W'(1)) begin
              if (!stat.len_ok) begin
                cmd.status = ST_TOOLONG;
                cmd.last   = 1'b1;
                state_nxt  = S_IDLE;
              end else begin
                cmd.load_len = 1'b1;
                idx_nxt      = IDX_W'(2);
                if (stat.len_zero) begin
                  cmd.last  = 1'b1;
                  state_nxt = S_IDLE;
                end
              end
            end else begin
              // body bytes: count down the length
              cmd.dec_len = 1'b1;
              if (stat.len_one) begin
                cmd.last  = 1'b1;
                state_nxt = S_IDLE;
              end
            end
          end
          default: begin
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= KIND_PUSH;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `BSDP_ASSERT_IMP(a_pop_not_empty, clk, rst_n, cmd.pop, !stat.empty,
    "pop issued on empty stack")
  `BSDP_ASSERT_IMP(a_push_idle, clk, rst_n, cmd.push, state_r == S_IDLE && start,
    "push issued outside an accepted item")
  `BSDP_ASSERT_IMP(a_error_is_last, clk, rst_n, cmd.emit && cmd.status != ST_OK, cmd.last,
    "error result not marked last")
  `BSDP_ASSERT_NXT(a_last_to_idle, clk, rst_n, cmd.emit && cmd.last, state_r == S_IDLE,
    "controller not idle after last result")

endmodule

[tb/sv/byte_stack_with_der_pop_tb.sv]
// Self-checking testbench for byte_stack_with_der_pop: push, pop, key pop and signature pop.
// Depends on bsdp_pkg and the byte_stack_with_der_pop RTL; keeps its own stack image
// to predict every result.
module byte_stack_with_der_pop_tb;
  import bsdp_pkg::*;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned SIG_LIMIT   = 64;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 185;

  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    status_t    status;
    logic       last;
  } stack_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_kind = 2'd0;
  logic [7:0] in_byte_in = 8'd0;
  logic       out_valid;
  logic [7:0] out_data_out;
  logic       out_has_data;
  logic [2:0] out_status;
  logic       out_last;

  // Predicted stack image and the results still owed by the block
  logic [7:0]    stack_mem [STACK_DEPTH];
  int unsigned   fill_level = 0;
  stack_result_t pending_results [$];

  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned items_sent = 0;
  int unsigned cmd_count [4] = '{0, 0, 0, 0};
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned calm_left = 0;

  byte_stack_with_der_pop #(
    .STACK_DEPTH(STACK_DEPTH),
    .SIG_LIMIT  (SIG_LIMIT)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_kind     (in_kind),
    .in_byte_in  (in_byte_in),
    .out_valid   (out_valid),
    .out_data_out(out_data_out),
    .out_has_data(out_has_data),
    .out_status  (out_status),
    .out_last    (out_last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic owe_result(logic [7:0] data, logic has_data, status_t status, logic last);
    pending_results.push_back('{data, has_data, status, last});
  endtask

  function automatic bit take_top(output logic [7:0] v);
    v = 8'd0;
    if (fill_level == 0) return 1'b0;
    fill_level--;
    v = stack_mem[fill_level];
    return 1'b1;
  endfunction

  task automatic stack_predict(kind_t kind, logic [7:0] byte_in);
    logic [7:0]  v;
    logic [7:0]  first;
    int unsigned len;
    first = 8'd0;
    case (kind)
      KIND_PUSH: begin
        if (fill_level >= STACK_DEPTH) begin
          owe_result(8'd0, 1'b0, ST_OVERFLOW, 1'b1);
        end else begin
          stack_mem[fill_level] = byte_in;
          fill_level++;
          owe_result(8'd0, 1'b0, ST_OK, 1'b1);
        end
      end
      KIND_POP: begin
        if (!take_top(v)) owe_result(8'd0, 1'b0, ST_UNDERFLOW, 1'b1);
        else owe_result(v, 1'b1, ST_OK, 1'b1);
      end
      KIND_KEY: begin
        for (int unsigned i = 0; i < KEY_LEN; i++) begin
          if (!take_top(v)) begin
            owe_result(8'd0, 1'b0, ST_UNDERFLOW, 1'b1);
            return;
          end
          if (i == 0) first = v;
          if (i + 1 < KEY_LEN) owe_result(v, 1'b1, ST_OK, 1'b0);
          else if (first == KEY_PFX_EVN || first == KEY_PFX_ODD)
            owe_result(v, 1'b1, ST_OK, 1'b1);
          else owe_result(v, 1'b1, ST_FORMAT, 1'b1);
        end
      end
      default: begin
        if (!take_top(v)) begin
          owe_result(8'd0, 1'b0, ST_UNDERFLOW, 1'b1);
          return;
        end
        if (v != DER_MARK) begin
          owe_result(v, 1'b1, ST_FORMAT, 1'b1);
          return;
        end
        owe_result(v, 1'b1, ST_OK, 1'b0);
        if (!take_top(v)) begin
          owe_result(8'd0, 1'b0, ST_UNDERFLOW, 1'b1);
          return;
        end
        len = {24'd0, v};
        if (2 + len > SIG_LIMIT) begin
          owe_result(v, 1'b1, ST_TOOLONG, 1'b1);
          return;
        end
        owe_result(v, 1'b1, ST_OK, len == 0);
        for (int unsigned i = 0; i < len; i++) begin
          if (!take_top(v)) begin
            owe_result(8'd0, 1'b0, ST_UNDERFLOW, 1'b1);
            return;
          end
          owe_result(v, 1'b1, ST_OK, i + 1 == len);
        end
      end
    endcase
  endtask

  // Compare each strobed result against the oldest prediction
  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing predicted, data", int'(out_data_out), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_out !== want.data)
          report_mismatch("data_out", int'(out_data_out), int'(want.data));
        if (out_has_data !== want.has_data)
          report_mismatch("has_data", int'(out_has_data), int'(want.has_data));
        if (out_status !== want.status)
          report_mismatch("status", int'(out_status), int'(want.status));
        if (out_last !== want.last) report_mismatch("last", int'(out_last), int'(want.last));
        results_checked++;
      end
    end
  end

  // Insert gaps between bursts; occasionally run a long stretch back to back
  task automatic pace_sender();
    if (calm_left > 0) begin
      calm_left--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      in_kind <= 2'($urandom_range(0, 3));
      in_byte_in <= 8'($urandom_range(0, 255));
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 10);
      if ($urandom_range(0, 7) == 0) calm_left = $urandom_range(10, 40);
    end
  endtask

  task automatic send_item(kind_t kind, logic [7:0] byte_in);
    start <= 1'b1;
    in_kind <= kind;
    in_byte_in <= byte_in;
    do @(posedge clk); while (busy);
    stack_predict(kind, byte_in);
    cmd_count[kind]++;
    items_sent++;
    pace_sender();
  endtask

  task automatic send_key(logic [7:0] prefix);
    repeat (KEY_LEN - 1) send_item(KIND_PUSH, 8'($urandom_range(0, 255)));
    send_item(KIND_PUSH, prefix);
    send_item(KIND_KEY, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_signature(int unsigned body_pushed, logic [7:0] len_byte,
                                logic [7:0] mark);
    repeat (body_pushed) send_item(KIND_PUSH, 8'($urandom_range(0, 255)));
    send_item(KIND_PUSH, len_byte);
    send_item(KIND_PUSH, mark);
    send_item(KIND_SIG, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_empty_underflow();
    send_item(KIND_POP, 8'h00);
    send_item(KIND_KEY, 8'hFF);
    send_item(KIND_SIG, 8'h5A);
  endtask

  task automatic test_push_pop_extremes();
    send_item(KIND_PUSH, 8'h00);
    send_item(KIND_PUSH, 8'hFF);
    send_item(KIND_POP, 8'hA5);
    send_item(KIND_POP, 8'h00);
  endtask

  task automatic test_signature_cases();
    send_item(KIND_PUSH, DER_MARK + 8'd1);
    send_item(KIND_SIG, 8'h00);
    // length just past the limit
    send_item(KIND_PUSH, 8'(SIG_LIMIT - 1));
    send_item(KIND_PUSH, DER_MARK);
    send_item(KIND_SIG, 8'h00);
    send_signature(0, 8'h00, DER_MARK);
    // marker with nothing under it
    send_item(KIND_PUSH, DER_MARK);
    send_item(KIND_SIG, 8'h00);
    // body runs out of bytes
    send_signature(1, 8'd2, DER_MARK);
  endtask

  task automatic test_key_underflow();
    send_item(KIND_PUSH, KEY_PFX_EVN);
    send_item(KIND_KEY, 8'h00);
  endtask

  task automatic test_random_traffic();
    int unsigned first_item;
    int unsigned pick;
    int unsigned len;
    first_item = items_sent;
    send_signature(SIG_LIMIT - 2, 8'(SIG_LIMIT - 2), DER_MARK);
    send_key(KEY_PFX_EVN);
    send_key(KEY_PFX_ODD);
    send_key(8'h04);
    while (items_sent - first_item < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (fill_level > STACK_DEPTH - 70) begin
        send_item(KIND_KEY, 8'($urandom_range(0, 255)));
      end else if (pick < 25) begin
        send_item(kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else if (pick < 45) begin
        send_key(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                 : ($urandom_range(0, 1) ? KEY_PFX_ODD : KEY_PFX_EVN));
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, SIG_LIMIT - 2)
              : $urandom_range(0, 8);
        pick = $urandom_range(0, 9);
        if (pick == 0) send_signature(len, 8'(len), 8'($urandom_range(0, 255)));
        else if (pick == 1)
          send_signature(len, 8'($urandom_range(SIG_LIMIT - 1, 255)), DER_MARK);
        else if (pick == 2) send_signature(len, 8'(len + $urandom_range(1, 6)), DER_MARK);
        else send_signature(len, 8'(len), DER_MARK);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_underflow();
    test_push_pop_extremes();
    test_signature_cases();
    test_key_underflow();
    test_random_traffic();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d pushes, %0d pops, %0d key pops, %0d signature pops",
             cmd_count[KIND_PUSH], cmd_count[KIND_POP], cmd_count[KIND_KEY],
             cmd_count[KIND_SIG]);
    $display("Compared %0d results, found %0d field errors", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
